FILE: rtl/brx_pkg.sv
`default_nettype none

package brx_pkg;

    // Fixed packet layout
    localparam int PKT_BYTES   = 11;
    localparam int CNT_W       = 4;
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // Reset values of the configuration registers
    localparam logic [7:0]  SYNC_RESET    = 8'hA5;
    localparam logic [7:0]  VERSION_RESET = 8'h03;
    localparam logic [15:0] GAP_RESET     = 16'd30;

    typedef enum logic [1:0] {
        CFG_SYNC    = 2'd0,
        CFG_VERSION = 2'd1,
        CFG_GAP     = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]  sync_byte;
        logic [7:0]  version_byte;
        logic [15:0] gap_limit_ms;
    } cfg_t;

    // One completed packet waiting for its check
    typedef struct packed {
        logic [2:0]  side;
        logic [15:0] heard_ms;
    } job_t;

    typedef struct packed {
        logic [2:0]         from_side;
        logic [7:0]         root_id;
        logic signed [7:0]  q_coord;
        logic signed [7:0]  r_coord;
        logic [2:0]         rotation;
        logic [2:0]         sender_side;
        logic [7:0]         hop_count;
        logic [7:0]         age_value;
        logic [15:0]        sender_time;
        logic [15:0]        heard_ms;
    } res_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EMIT
    } bk_state_t;

    // First buffer address of a side's row; at most 7 * 11 = 77
    function automatic logic [7:0] row_base(input logic [2:0] side);
        row_base = {2'b00, side, 3'b000} + {4'b0000, side, 1'b0} + {5'b00000, side};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/brx_ram.sv
`default_nettype none

module brx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 66
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/brx_job_fifo.sv
`default_nettype none

module brx_job_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire brx_pkg::job_t push_job,
    input  wire logic          pop,
    output brx_pkg::job_t      head,
    output logic               empty,
    output logic               full,
    input  wire logic [2:0]    probe_side,
    output logic               probe_hit
);
    import brx_pkg::*;

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    job_t            ent_reg [DEPTH];
    logic [DEPTH-1:0] vld_reg, vld_next;
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;

    assign head  = ent_reg[rd_ptr_reg];
    assign empty = !vld_reg[rd_ptr_reg];
    assign full  = vld_reg[wr_ptr_reg];

    // A side with a packet queued or under check must not be rewritten
    always_comb begin
        probe_hit = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            if (vld_reg[i] && ent_reg[i].side == probe_side) begin
                probe_hit = 1'b1;
            end
        end
    end

    always_comb begin
        vld_next    = vld_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (pop) begin
            vld_next[rd_ptr_reg] = 1'b0;
            rd_ptr_next          = rd_ptr_reg + 1'b1;
        end
        if (push) begin
            vld_next[wr_ptr_reg] = 1'b1;
            wr_ptr_next          = wr_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            vld_reg    <= vld_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full) else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty) else $error("job popped from an empty queue");

endmodule

`default_nettype wire

FILE: rtl/brx_front.sv
`default_nettype none

module brx_front #(
    parameter int SIDE_COUNT = 6,
    parameter int AW         = 7
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire brx_pkg::cfg_t cfg,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [23:0]   s_tdata,
    input  wire logic [3:0]    s_tuser,
    input  wire logic          q_full,
    input  wire logic          q_hit,
    output logic               q_push,
    output brx_pkg::job_t      q_job,
    output logic               ram_we,
    output logic [AW-1:0]      ram_waddr,
    output logic [7:0]         ram_wdata
);
    import brx_pkg::*;

    localparam int SW = (SIDE_COUNT > 1) ? $clog2(SIDE_COUNT) : 1;

    logic [CNT_W-1:0] fill_reg [SIDE_COUNT];
    logic [CNT_W-1:0] fill_next [SIDE_COUNT];
    logic [15:0]      last_reg [SIDE_COUNT];
    logic [15:0]      last_next [SIDE_COUNT];

    logic [2:0]       side;
    logic [7:0]       rx_byte;
    logic             stop_ok;
    logic [15:0]      now_ms;
    logic [SW-1:0]    sidx;
    logic             in_range;
    logic             accept;
    logic [15:0]      gap;
    logic [CNT_W-1:0] pos;

    assign side    = s_tuser[2:0];
    assign stop_ok = s_tuser[3];
    assign rx_byte = s_tdata[7:0];
    assign now_ms  = s_tdata[23:8];
    assign sidx    = SW'(side);
    assign in_range = 32'(side) < SIDE_COUNT;

    assign s_tready = !q_full && !q_hit;
    assign accept   = s_tvalid && s_tready;

    assign q_job.side     = side;
    assign q_job.heard_ms = now_ms;
    assign ram_wdata      = rx_byte;
    assign ram_waddr      = AW'(row_base(side) + 8'(pos));
    assign gap            = now_ms - last_reg[sidx];

    always_comb begin
        fill_next = fill_reg;
        last_next = last_reg;
        q_push    = 1'b0;
        ram_we    = 1'b0;
        pos       = fill_reg[sidx];
        // a long silence restarts assembly
        if (gap > cfg.gap_limit_ms || pos >= CNT_W'(PKT_BYTES)) begin
            pos = '0;
        end
        if (accept && in_range) begin
            if (!stop_ok) begin
                fill_next[sidx] = '0;
            end else begin
                last_next[sidx] = now_ms;
                if (pos == '0 && rx_byte != cfg.sync_byte) begin
                    fill_next[sidx] = '0;
                end else begin
                    ram_we = 1'b1;
                    if (pos == CNT_W'(PKT_BYTES - 1)) begin
                        fill_next[sidx] = '0;
                        q_push          = 1'b1;
                    end else begin
                        fill_next[sidx] = pos + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SIDE_COUNT; i++) begin
                fill_reg[i] <= '0;
                last_reg[i] <= '0;
            end
        end else begin
            fill_reg <= fill_next;
            last_reg <= last_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/brx_back.sv
`default_nettype none

module brx_back #(
    parameter int AW = 7
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire brx_pkg::cfg_t cfg,
    input  wire brx_pkg::job_t q_head,
    input  wire logic          q_empty,
    output logic               q_pop,
    output logic               ram_re,
    output logic [AW-1:0]      ram_raddr,
    input  wire logic [7:0]    ram_rdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output brx_pkg::res_t      m_res
);
    import brx_pkg::*;

    // One byte of the reflected CRC-8, bit by bit
    function automatic logic [7:0] crc8_byte(input logic [7:0] acc_in, input logic [7:0] v);
        logic [7:0] acc;
        acc = acc_in;
        for (int k = 0; k < 8; k++) begin
            if (acc[0] ^ v[k]) begin
                acc = (acc >> 1) ^ CRC_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

    bk_state_t        st_reg, st_next;
    job_t             job_reg, job_next;
    logic [AW-1:0]    base_reg, base_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rd_vld_reg;
    logic [CNT_W-1:0] rd_num_reg;
    logic [7:0]       crc_reg, crc_next;
    logic             ok_reg, ok_next;
    res_t             wk_reg, wk_next;
    res_t             out_reg, out_next;
    logic             out_vld_reg, out_vld_next;
    logic             can_load;

    assign ram_re    = (st_reg == BK_READ) && (rd_idx_reg < CNT_W'(PKT_BYTES));
    assign ram_raddr = AW'(base_reg + AW'(rd_idx_reg));
    assign can_load  = !out_vld_reg || m_tready;
    assign m_tvalid  = out_vld_reg;
    assign m_res     = out_reg;

    always_comb begin
        st_next      = st_reg;
        job_next     = job_reg;
        base_next    = base_reg;
        rd_idx_next  = rd_idx_reg;
        crc_next     = crc_reg;
        ok_next      = ok_reg;
        wk_next      = wk_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg && !m_tready;
        q_pop        = 1'b0;
        unique case (st_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    job_next    = q_head;
                    base_next   = AW'(row_base(q_head.side));
                    rd_idx_next = '0;
                    crc_next    = '0;
                    ok_next     = 1'b1;
                    st_next     = BK_READ;
                end
            end
            BK_READ: begin
                if (ram_re) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (rd_vld_reg) begin
                    unique case (rd_num_reg)
                        4'd0: ok_next = ok_reg && (ram_rdata == cfg.sync_byte);
                        4'd1: begin
                            ok_next  = ok_reg && (ram_rdata == cfg.version_byte);
                            crc_next = crc8_byte(crc_reg, ram_rdata);
                        end
                        4'd10: begin
                            ok_next = ok_reg && (ram_rdata == crc_reg);
                            st_next = BK_EMIT;
                        end
                        default: begin
                            crc_next = crc8_byte(crc_reg, ram_rdata);
                            priority case (rd_num_reg)
                                4'd2: wk_next.root_id = ram_rdata;
                                4'd3: wk_next.q_coord = ram_rdata;
                                4'd4: wk_next.r_coord = ram_rdata;
                                4'd5: begin
                                    wk_next.rotation    = ram_rdata[5:3];
                                    wk_next.sender_side = ram_rdata[2:0];
                                end
                                4'd6: wk_next.hop_count = ram_rdata;
                                4'd7: wk_next.age_value = ram_rdata;
                                4'd8: wk_next.sender_time[7:0] = ram_rdata;
                                default: wk_next.sender_time[15:8] = ram_rdata;
                            endcase
                        end
                    endcase
                end
            end
            BK_EMIT: begin
                if (can_load) begin
                    if (ok_reg) begin
                        out_next           = wk_reg;
                        out_next.from_side = job_reg.side;
                        out_next.heard_ms  = job_reg.heard_ms;
                        out_vld_next       = 1'b1;
                    end
                    q_pop   = 1'b1;
                    st_next = BK_IDLE;
                end
            end
            default: st_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= BK_IDLE;
            out_vld_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
        end else begin
            st_reg      <= st_next;
            out_vld_reg <= out_vld_next;
            rd_vld_reg  <= ram_re;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        base_reg   <= base_next;
        rd_idx_reg <= rd_idx_next;
        rd_num_reg <= rd_idx_reg;
        crc_reg    <= crc_next;
        ok_reg     <= ok_next;
        wk_reg     <= wk_next;
        out_reg    <= out_next;
    end

    a_job_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != BK_IDLE) |-> !q_empty) else $error("check running without a queued job");

    a_read_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == BK_EMIT) |-> !ram_re) else $error("buffer read after the last byte");

endmodule

`default_nettype wire

FILE: rtl/beacon_packet_receiver.sv
`default_nettype none

// Channel   Direction  Handshake            Contents (lowest bit first)
// s_*       in         s_tvalid / s_tready  tdata: rx_byte, now_ms; tuser: side, stop_ok
// m_*       out        m_tvalid / m_tready  tdata: decoded beacon fields; tuser: from_side
// cfg_*     in         cfg_wr_en            cfg_index selects register, cfg_data value
//
// Flow: a finishing byte queues a check job, and the checker reads the 11 buffered
// bytes through the single read port of the packet buffer; meanwhile bytes of
// other sides are still taken.
// Reset: aresetn clears fill counts, byte times, queue and output; buffer is not cleared.
// Stalls: s_tready drops while the job queue is full or while the byte's side still
// has a packet queued or under check; a stalled output holds the checker only.

module beacon_packet_receiver #(
    parameter int SIDE_COUNT = 6
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // received bytes
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] rx_byte, [23:8] now_ms
    input  wire logic [3:0]  s_tuser,   // [2:0] side, [3] stop_ok
    // decoded beacons
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // [7:0] root_id, [15:8] q_coord, [23:16] r_coord,
                                        // [26:24] rotation, [29:27] sender_side,
                                        // [37:30] hop_count, [45:38] age_value,
                                        // [61:46] sender_time, [77:62] heard_ms, rest zero
    output logic [2:0]       m_tuser    // [2:0] from_side
);
    import brx_pkg::*;

    localparam int DEPTH = SIDE_COUNT * PKT_BYTES;
    localparam int AW    = $clog2(DEPTH);

    cfg_t          cfg_reg;
    logic          q_push, q_pop, q_empty, q_full, q_hit;
    job_t          q_job, q_head;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;
    res_t          res;

    // Take configuration writes at any time; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_byte    <= SYNC_RESET;
            cfg_reg.version_byte <= VERSION_RESET;
            cfg_reg.gap_limit_ms <= GAP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SYNC:    cfg_reg.sync_byte    <= cfg_data[7:0];
                CFG_VERSION: cfg_reg.version_byte <= cfg_data[7:0];
                CFG_GAP:     cfg_reg.gap_limit_ms <= cfg_data;
                default:     cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Front: per-side framing, fill counts and gap timing; writes the buffer
    brx_front #(
        .SIDE_COUNT (SIDE_COUNT),
        .AW         (AW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_hit     (q_hit),
        .q_push    (q_push),
        .q_job     (q_job),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    // Packet buffer: one row of 11 bytes per side
    brx_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_buf (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Completed packets wait here; the head stays until its check ends
    brx_job_fifo u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_job),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full),
        .probe_side (s_tuser[2:0]),
        .probe_hit  (q_hit)
    );

    // Back: version and CRC check, field decode, output register
    brx_back #(
        .AW (AW)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (res)
    );

    assign m_tdata = {2'b00, res.heard_ms, res.sender_time, res.age_value, res.hop_count,
                      res.sender_side, res.rotation, res.r_coord, res.q_coord, res.root_id};
    assign m_tuser = res.from_side;

    // Never overwrite a row whose packet is still queued or under check
    a_no_row_clobber: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !q_hit) else $error("buffer row of a pending packet rewritten");

endmodule

`default_nettype wire

FILE: sim/tb_beacon_packet_receiver.sv
`default_nettype none

// Checks the beacon deframer against a cycle-free prediction of its per-side packet
// assembly. Bytes go in as items on s_*, decoded beacons come back on m_*. Both sides
// idle at random, and the result side holds off once for a long stretch so that the
// check queue fills and the block stalls its input.

module tb_beacon_packet_receiver;

    import brx_pkg::*;

    localparam int SIDE_COUNT  = 6;
    localparam int PHASE_BYTES = 250;
    // Timestamp advance codes in a planned byte; a value of zero or more is exact
    localparam int STEP_RANDOM = -1;
    localparam int STEP_LONG   = -2;

    typedef logic [7:0] packet_t [PKT_BYTES];

    typedef struct {
        logic [2:0]  side;
        logic [7:0]  rx_byte;
        logic        stop_ok;
        logic [15:0] now_ms;
    } rx_item_t;

    // One byte as planned, before its timestamp is fixed
    typedef struct {
        logic [2:0] side;
        logic [7:0] data;
        logic       stop;
        int         delta;
    } plan_t;

    typedef plan_t plan_q_t [$];

    typedef enum {
        FLAW_NONE,
        FLAW_VERSION,
        FLAW_CRC,
        FLAW_FRAMING,
        FLAW_GAP,
        FLAW_NOISE
    } flaw_t;

    // Reflected CRC-8 with polynomial 0x8C over bytes 1 to 9 of a packet
    function automatic logic [7:0] packet_crc(input packet_t p);
        logic [7:0] acc;
        logic [7:0] v;
        int k;
        int b;
        acc = 8'h00;
        for (k = 1; k <= 9; k++) begin
            v = p[k];
            for (b = 0; b < 8; b++) begin
                if (acc[0] ^ v[0]) begin
                    acc = (acc >> 1) ^ CRC_POLY;
                end else begin
                    acc = acc >> 1;
                end
                v = v >> 1;
            end
        end
        return acc;
    endfunction

    // Per-side assembly state mirrored from the items the block has taken,
    // plus the beacons it still owes us
    class neighbour_tracker;
        logic [7:0]  sync_val;
        logic [7:0]  version_val;
        logic [15:0] gap_val;
        packet_t     rows [SIDE_COUNT];
        logic [3:0]  fill [SIDE_COUNT];
        logic [15:0] last_ms [SIDE_COUNT];
        res_t        due_beacons [$];
        int          errors;
        int          results_seen;

        function new();
            int s;
            int k;
            sync_val     = SYNC_RESET;
            version_val  = VERSION_RESET;
            gap_val      = GAP_RESET;
            errors       = 0;
            results_seen = 0;
            for (s = 0; s < SIDE_COUNT; s++) begin
                fill[s]    = '0;
                last_ms[s] = '0;
                for (k = 0; k < PKT_BYTES; k++) rows[s][k] = '0;
            end
        endfunction

        function void set_reg(input cfg_index_t idx, input logic [15:0] value);
            case (idx)
                CFG_SYNC:    sync_val    = value[7:0];
                CFG_VERSION: version_val = value[7:0];
                CFG_GAP:     gap_val     = value;
                default: ;
            endcase
        endfunction

        function void take_byte(input rx_item_t it);
            logic [3:0]  n;
            logic [15:0] since;
            res_t        r;
            if (it.side >= SIDE_COUNT) return;
            if (!it.stop_ok) begin
                fill[it.side] = '0;
                return;
            end
            since = it.now_ms - last_ms[it.side];
            if (since > gap_val) fill[it.side] = '0;
            last_ms[it.side] = it.now_ms;
            n = fill[it.side];
            if (n >= PKT_BYTES) n = '0;
            if (n == 0 && it.rx_byte != sync_val) begin
                fill[it.side] = '0;
                return;
            end
            rows[it.side][n] = it.rx_byte;
            n = n + 1'b1;
            if (n < PKT_BYTES) begin
                fill[it.side] = n;
                return;
            end
            fill[it.side] = '0;
            if (rows[it.side][0] != sync_val || rows[it.side][1] != version_val) return;
            if (packet_crc(rows[it.side]) != rows[it.side][10]) return;
            r.from_side   = it.side;
            r.root_id     = rows[it.side][2];
            r.q_coord     = rows[it.side][3];
            r.r_coord     = rows[it.side][4];
            r.rotation    = rows[it.side][5][5:3];
            r.sender_side = rows[it.side][5][2:0];
            r.hop_count   = rows[it.side][6];
            r.age_value   = rows[it.side][7];
            r.sender_time = {rows[it.side][9], rows[it.side][8]};
            r.heard_ms    = it.now_ms;
            due_beacons.push_back(r);
        endfunction

        function void compare(input string name, input logic [15:0] want,
                              input logic [15:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void match_beacon(input logic [79:0] data, input logic [2:0] tag);
            res_t want;
            results_seen++;
            if (due_beacons.size() == 0) begin
                $error("from_side: expected no beacon, actual beacon from side %0d", tag);
                errors++;
                return;
            end
            want = due_beacons.pop_front();
            compare("from_side",   want.from_side,            tag);
            compare("root_id",     want.root_id,              data[7:0]);
            compare("q_coord",     $unsigned(want.q_coord),   data[15:8]);
            compare("r_coord",     $unsigned(want.r_coord),   data[23:16]);
            compare("rotation",    want.rotation,             data[26:24]);
            compare("sender_side", want.sender_side,          data[29:27]);
            compare("hop_count",   want.hop_count,            data[37:30]);
            compare("age_value",   want.age_value,            data[45:38]);
            compare("sender_time", want.sender_time,          data[61:46]);
            compare("heard_ms",    want.heard_ms,             data[77:62]);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    cfg_index_t  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [7:0] rx_byte, [23:8] now_ms
    logic [3:0]  s_tuser;   // [2:0] side, [3] stop_ok
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;   // root_id, q_coord, r_coord, rotation, sender_side,
                            // hop_count, age_value, sender_time, heard_ms
    logic [2:0]  m_tuser;   // [2:0] from_side

    neighbour_tracker tracker = new();

    // Settings as the stimulus sees them, used to build well-formed packets
    logic [7:0]  cur_sync;
    logic [7:0]  cur_ver;
    logic [15:0] cur_gap;
    logic [15:0] stamp;
    int          bytes_taken;
    int          send_calm;
    plan_q_t     carry;

    beacon_packet_receiver #(
        .SIDE_COUNT(SIDE_COUNT)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Give up well past the slowest correct run
    initial begin
        #3_000_000;
        $display("tb_beacon_packet_receiver failed");
        $finish;
    end

    // Offer one byte, stamped here, and hold it until the block takes it.
    // Called at a rising edge; returns at the edge where the item was taken.
    task automatic send_byte(input plan_t p);
        int unsigned hop;
        int unsigned spare;
        int unsigned idle;
        rx_item_t    it;
        if (p.delta >= 0) begin
            hop = p.delta;
        end else if (p.delta == STEP_LONG && cur_gap != 16'hFFFF) begin
            // push this side's gap just past the limit
            spare = 65534 - cur_gap;
            if (spare > 50) spare = 50;
            hop = cur_gap + 1 + $urandom_range(0, spare);
        end else begin
            hop = $urandom_range(0, (cur_gap >= 64) ? 3 : (cur_gap >= 16) ? 1 : 0);
        end
        stamp = stamp + hop[15:0];
        it = '{p.side, p.data, p.stop, stamp};
        if (send_calm > 0) begin
            send_calm--;
            idle = 0;
        end else begin
            idle = $urandom_range(0, 9);
            if ($urandom_range(0, 40) == 0) send_calm = $urandom_range(10, 40);
        end
        if (idle != 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.now_ms, it.rx_byte};
        s_tuser  <= {it.stop_ok, it.side};
        do @(posedge aclk); while (!s_tready);
        tracker.take_byte(it);
        if (it.side < SIDE_COUNT) bytes_taken++;
    endtask

    // Plan the bytes of one run on a side: a packet, mostly well-formed, or a bit of noise
    function automatic plan_q_t build_run(input logic [2:0] side, input bit clean);
        plan_q_t seq;
        packet_t pk;
        flaw_t   flaw;
        int      r;
        int      k;
        int      count;
        int      spot;
        r = $urandom_range(0, 99);
        if (clean || r < 60) flaw = FLAW_NONE;
        else if (r < 68)     flaw = FLAW_VERSION;
        else if (r < 76)     flaw = FLAW_CRC;
        else if (r < 84)     flaw = FLAW_FRAMING;
        else if (r < 90)     flaw = FLAW_GAP;
        else                 flaw = FLAW_NOISE;
        if (flaw == FLAW_NOISE) begin
            count = $urandom_range(1, 4);
            for (k = 0; k < count; k++) begin
                seq.push_back('{side, 8'($urandom), $urandom_range(0, 5) != 0, STEP_RANDOM});
            end
            return seq;
        end
        pk[0] = cur_sync;
        pk[1] = cur_ver;
        for (k = 2; k < PKT_BYTES; k++) pk[k] = 8'($urandom);
        if (flaw == FLAW_VERSION) pk[1] = pk[1] ^ (8'h01 << $urandom_range(0, 7));
        pk[10] = packet_crc(pk);
        if (flaw == FLAW_CRC) pk[10] = pk[10] ^ 8'($urandom_range(1, 255));
        for (k = 0; k < PKT_BYTES; k++) seq.push_back('{side, pk[k], 1'b1, STEP_RANDOM});
        spot = $urandom_range(1, PKT_BYTES - 1);
        if (flaw == FLAW_FRAMING) seq[spot].stop = 1'b0;
        if (flaw == FLAW_GAP) seq[spot].delta = STEP_LONG;
        return seq;
    endfunction

    // Wait for every owed beacon, then let the checker run dry before touching settings
    task automatic drain_results();
        int k;
        for (k = 0; k < 20000 && tracker.due_beacons.size() != 0; k++) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_settings(input logic [7:0] sync_v, input logic [7:0] ver_v,
                                  input logic [15:0] gap_v);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SYNC;
        cfg_data  <= {8'h00, sync_v};
        @(posedge aclk);
        cfg_index <= CFG_VERSION;
        cfg_data  <= {8'h00, ver_v};
        @(posedge aclk);
        cfg_index <= CFG_GAP;
        cfg_data  <= gap_v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_sync = sync_v;
        cur_ver  = ver_v;
        cur_gap  = gap_v;
        tracker.set_reg(CFG_SYNC, {8'h00, sync_v});
        tracker.set_reg(CFG_VERSION, {8'h00, ver_v});
        tracker.set_reg(CFG_GAP, gap_v);
    endtask

    // Random traffic under one setting: bursts of up to three sides interleaved,
    // with stray bytes now and then. Optionally leave one packet half-built so
    // that the next setting has to finish it.
    task automatic run_phase(input int target, input bit leave_open);
        plan_q_t a;
        plan_q_t b;
        plan_q_t c;
        plan_t   p;
        int      lanes;
        int      pick;
        int      base;
        int      off;
        int      k;
        int      start_count;
        start_count = bytes_taken;
        // finish the packet left open under the previous setting first
        while (carry.size() != 0) send_byte(carry.pop_front());
        while (bytes_taken - start_count < target) begin
            lanes = $urandom_range(1, 3);
            base  = $urandom_range(0, SIDE_COUNT - 1);
            off   = $urandom_range(1, 2);
            if ($urandom_range(0, 2) == 0) stamp = 16'($urandom);
            a = build_run(3'(base), 1'b0);
            b.delete();
            c.delete();
            if (lanes > 1) b = build_run(3'((base + off) % SIDE_COUNT), 1'b0);
            if (lanes > 2) c = build_run(3'((base + 2 * off) % SIDE_COUNT), 1'b0);
            while (a.size() + b.size() + c.size() > 0) begin
                if ($urandom_range(0, 23) == 0) begin
                    send_byte('{3'($urandom_range(0, 7)), 8'($urandom),
                                $urandom_range(0, 7) != 0, STEP_RANDOM});
                end
                do pick = $urandom_range(0, 2);
                while ((pick == 0 && a.size() == 0) || (pick == 1 && b.size() == 0) ||
                       (pick == 2 && c.size() == 0));
                case (pick)
                    0:       p = a.pop_front();
                    1:       p = b.pop_front();
                    default: p = c.pop_front();
                endcase
                send_byte(p);
            end
        end
        if (leave_open) begin
            carry = build_run(3'($urandom_range(0, SIDE_COUNT - 1)), 1'b1);
            for (k = $urandom_range(1, PKT_BYTES - 1); k > 0; k--) send_byte(carry.pop_front());
        end
        s_tvalid <= 1'b0;
    endtask

    // Result side: take beacons with random hold-offs, calm stretches, and one long
    // hold-off early on while the sender keeps offering bytes
    initial begin : beacon_sink
        int unsigned idle;
        int          calm;
        bit          held;
        calm = 0;
        held = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (!held && tracker.results_seen == 5) begin
                held = 1'b1;
                idle = 600;
            end else if (calm > 0) begin
                calm--;
                idle = 0;
            end else begin
                idle = $urandom_range(0, 9);
                if ($urandom_range(0, 30) == 0) calm = $urandom_range(10, 30);
            end
            if (idle != 0) begin
                m_tready <= 1'b0;
                repeat (idle) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            tracker.match_beacon(m_tdata, m_tuser);
        end
    end

    initial begin : byte_source
        packet_t pk;
        int      k;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_SYNC;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cur_sync    = SYNC_RESET;
        cur_ver     = VERSION_RESET;
        cur_gap     = GAP_RESET;
        stamp       = 16'hFFF0;
        bytes_taken = 0;
        send_calm   = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, under the reset settings.
        // Sides beyond the last one are ignored outright.
        send_byte('{3'd7, SYNC_RESET, 1'b1, 0});
        send_byte('{3'd6, 8'h00, 1'b1, 0});
        // Waiting for sync drops a stray byte; a framing error clears the side.
        send_byte('{3'd3, 8'h00, 1'b1, 0});
        send_byte('{3'd3, SYNC_RESET, 1'b0, 0});
        // Full packet at the field extremes, one gap exactly at the limit,
        // and the time wrapping through zero.
        pk = '{SYNC_RESET, VERSION_RESET, 8'hFF, 8'h80, 8'h7F, 8'hFF,
               8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        pk[10] = packet_crc(pk);
        for (k = 0; k < PKT_BYTES; k++) begin
            send_byte('{3'd5, pk[k], 1'b1, (k == 0) ? 0 : (k == 4) ? 30 : 1});
        end
        // A gap one beyond the limit restarts assembly, so the next byte is dropped.
        send_byte('{3'd0, SYNC_RESET, 1'b1, 1});
        send_byte('{3'd0, VERSION_RESET, 1'b1, 1});
        send_byte('{3'd0, 8'h11, 1'b1, 31});
        // Framing error in the middle of a packet.
        send_byte('{3'd1, SYNC_RESET, 1'b1, 1});
        send_byte('{3'd1, VERSION_RESET, 1'b1, 1});
        send_byte('{3'd1, 8'h5A, 1'b0, 1});

        // Random part across several settings, the extremes among them
        run_phase(PHASE_BYTES, 1'b1);
        drain_results();
        write_settings(8'h00, 8'hFF, 16'hFFFF);
        run_phase(PHASE_BYTES, 1'b1);
        drain_results();
        write_settings(8'hFF, 8'h00, 16'h0000);
        run_phase(PHASE_BYTES, 1'b1);
        drain_results();
        write_settings(8'($urandom), 8'($urandom), 16'($urandom_range(20, 300)));
        run_phase(PHASE_BYTES, 1'b0);
        drain_results();

        if (tracker.due_beacons.size() != 0) begin
            $error("%0d beacons expected but never delivered", tracker.due_beacons.size());
            tracker.errors += tracker.due_beacons.size();
        end
        if (tracker.errors == 0) begin
            $display("tb_beacon_packet_receiver passed");
        end else begin
            $display("tb_beacon_packet_receiver failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
